// ===== hdl/bbd_pkg.sv =====
// package with constants and types for the bayer bilinear demosaic core
`default_nettype none

package bbd_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int OUT_BITS    = SAMPLE_BITS + 2;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);

    localparam int FW_BITS     = 12;
    localparam int FH_BITS     = 13;
    localparam int CFG_BITS    = 13;
    localparam int REG_IDX_BITS = 2;

    localparam logic [FW_BITS-1:0] FW_RESET = FW_BITS'(640);
    localparam logic [FH_BITS-1:0] FH_RESET = FH_BITS'(480);
    localparam logic [FW_BITS-1:0] FW_MIN   = FW_BITS'(3);
    localparam logic [FW_BITS-1:0] FW_MAX   = FW_BITS'(MAX_WIDTH);
    localparam logic [FH_BITS-1:0] FH_MIN   = FH_BITS'(3);
    localparam logic [FH_BITS-1:0] FH_MAX   = FH_BITS'(MAX_HEIGHT);

    // configuration register indexes
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_FRAME_WIDTH  = REG_IDX_BITS'(0),
        REG_FRAME_HEIGHT = REG_IDX_BITS'(1)
    } bbd_reg_t;

    // position flags of the sample held in the input stage
    typedef struct packed {
        logic produce;   // interior pixel, gives a result
        logic row_odd;   // centre row is odd
        logic col_odd;   // centre column is odd
        logic last_col;
        logic last_row;
    } bbd_pos_t;

endpackage

`default_nettype wire

// ===== hdl/bayer_bilinear_demosaic_core.sv =====
// top level of the bayer bilinear demosaic core: line stores, 3x3 window, rgb output
`default_nettype none

// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// input    | in_valid, in_ready, raw_sample            | sink
// output   | out_valid, out_ready, red_value,          | source
//          | green_value, blue_value, row_end,         |
//          | frame_end                                 |
// config   | cfg_we, cfg_index, cfg_data               | write only
//
// one sample per cycle sustained while the output is not stalled; an accepted sample passes
// the input stage register (with the line store read register), then the result register
// border samples are accepted but give no output transaction
// the line stores need no clearing after reset; counters restart at row 0, column 0
// a stalled output holds the input stage; in_ready drops only when both are full
// a configuration write restarts the frame counters at once; unused indexes are ignored

module bayer_bilinear_demosaic_core
    import bbd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [SAMPLE_BITS-1:0]  raw_sample,

    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [OUT_BITS-1:0]          red_value,
    output logic [OUT_BITS-1:0]          green_value,
    output logic [OUT_BITS-1:0]          blue_value,
    output logic                         row_end,
    output logic                         frame_end,

    input  wire logic                    cfg_we,
    input  wire logic [REG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]     cfg_data
);

    // configuration
    logic [FW_BITS-1:0]     frame_width_reg;
    logic [FH_BITS-1:0]     frame_height_reg;
    logic [COL_BITS-1:0]    width_m1;
    logic [ROW_BITS-1:0]    height_m1;
    logic                   cfg_hit;

    // raster position of the next sample
    logic [COL_BITS-1:0]    col_cnt_reg, col_cnt_next;
    logic [ROW_BITS-1:0]    row_cnt_reg, row_cnt_next;
    logic                   at_last_col;
    logic                   at_last_row;

    // line stores and their registered read data
    logic [SAMPLE_BITS-1:0] upper_mem  [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] middle_mem [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] upper_rd_reg;
    logic [SAMPLE_BITS-1:0] middle_rd_reg;

    // input stage
    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [COL_BITS-1:0]    s1_col_reg;
    bbd_pos_t               s1_pos_reg;
    bbd_pos_t               pos_next;

    // two previous columns of the three window rows
    logic [SAMPLE_BITS-1:0] win_reg [6];

    // output register
    logic                   out_valid_reg;
    logic [OUT_BITS-1:0]    red_reg, green_reg, blue_reg;
    logic                   row_end_reg, frame_end_reg;

    logic                   in_fire;
    logic                   s1_adv;

    // window taps
    logic [SAMPLE_BITS-1:0] t0, t1, t2, m0, m1, m2, b0, b1, b2;
    logic [OUT_BITS-1:0]    edge_sum, diag_sum, horiz_sum, vert_sum, own_val;
    logic [OUT_BITS-1:0]    red_calc, green_calc, blue_calc;

    // ---------------------------------------------------------------
    // configuration registers, clamped to the supported frame sizes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // only writes to a known register restart the frame
    assign cfg_hit = cfg_we &&
                     ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

    always_comb
    begin
        logic [FW_BITS-1:0] w_eff;
        logic [FH_BITS-1:0] h_eff;
        priority if (frame_width_reg < FW_MIN)
            w_eff = FW_MIN;
        else if (frame_width_reg > FW_MAX)
            w_eff = FW_MAX;
        else
            w_eff = frame_width_reg;
        priority if (frame_height_reg < FH_MIN)
            h_eff = FH_MIN;
        else if (frame_height_reg > FH_MAX)
            h_eff = FH_MAX;
        else
            h_eff = frame_height_reg;
        width_m1  = COL_BITS'(w_eff - 1'b1);
        height_m1 = ROW_BITS'(h_eff - 1'b1);
    end

    // ---------------------------------------------------------------
    // handshake: input stage moves on whenever the output register frees
    // ---------------------------------------------------------------
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    // ---------------------------------------------------------------
    // raster counters
    // ---------------------------------------------------------------
    assign at_last_col = (col_cnt_reg >= width_m1);
    assign at_last_row = (row_cnt_reg >= height_m1);

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (cfg_hit)
        begin
            // a write to a known register restarts the frame
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (in_fire)
        begin
            if (at_last_col)
            begin
                col_cnt_next = '0;
                row_cnt_next = at_last_row ? '0 : row_cnt_reg + 1'b1;
            end
            else
            begin
                col_cnt_next = col_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // position flags of the incoming sample; the window centre is one row
    // up and one column left of it
    always_comb
    begin
        pos_next.produce  = (col_cnt_reg >= COL_BITS'(2)) && (row_cnt_reg >= ROW_BITS'(2));
        pos_next.row_odd  = !row_cnt_reg[0];
        pos_next.col_odd  = !col_cnt_reg[0];
        pos_next.last_col = at_last_col;
        pos_next.last_row = at_last_row;
    end

    // ---------------------------------------------------------------
    // input stage register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sample_reg <= raw_sample;
            s1_col_reg    <= col_cnt_reg;
            s1_pos_reg    <= pos_next;
        end
    end

    // ---------------------------------------------------------------
    // line stores: read at the incoming column on acceptance, written
    // back when the sample leaves the input stage; with at least three
    // columns the read and write addresses never collide
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            upper_rd_reg  <= upper_mem[col_cnt_reg];
            middle_rd_reg <= middle_mem[col_cnt_reg];
        end
        if (s1_adv)
        begin
            upper_mem[s1_col_reg]  <= middle_rd_reg;
            middle_mem[s1_col_reg] <= s1_sample_reg;
        end
    end

    // ---------------------------------------------------------------
    // 3x3 window: rows top, middle, bottom; columns 0 oldest, 2 newest
    // ---------------------------------------------------------------
    assign t0 = win_reg[0];
    assign t1 = win_reg[1];
    assign t2 = upper_rd_reg;
    assign m0 = win_reg[2];
    assign m1 = win_reg[3];
    assign m2 = middle_rd_reg;
    assign b0 = win_reg[4];
    assign b1 = win_reg[5];
    assign b2 = s1_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (s1_adv)
        begin
            win_reg[0] <= t1;
            win_reg[1] <= t2;
            win_reg[2] <= m1;
            win_reg[3] <= m2;
            win_reg[4] <= b1;
            win_reg[5] <= b2;
        end
    end

    // ---------------------------------------------------------------
    // interpolation in quarters: 4-neighbour mean is the plain sum,
    // 2-neighbour mean is twice the sum, own sample is four times itself
    // ---------------------------------------------------------------
    assign edge_sum  = OUT_BITS'(t1) + OUT_BITS'(m0) + OUT_BITS'(m2) + OUT_BITS'(b1);
    assign diag_sum  = OUT_BITS'(t0) + OUT_BITS'(t2) + OUT_BITS'(b0) + OUT_BITS'(b2);
    assign horiz_sum = (OUT_BITS'(m0) + OUT_BITS'(m2)) << 1;
    assign vert_sum  = (OUT_BITS'(t1) + OUT_BITS'(b1)) << 1;
    assign own_val   = OUT_BITS'(m1) << 2;

    always_comb
    begin
        unique case ({s1_pos_reg.row_odd, s1_pos_reg.col_odd})
            2'b11:
            begin
                // red site
                red_calc   = own_val;
                green_calc = edge_sum;
                blue_calc  = diag_sum;
            end
            2'b10:
            begin
                // green site on a red row
                red_calc   = horiz_sum;
                green_calc = own_val;
                blue_calc  = vert_sum;
            end
            2'b01:
            begin
                // green site on a blue row
                red_calc   = vert_sum;
                green_calc = own_val;
                blue_calc  = horiz_sum;
            end
            default:
            begin
                // blue site
                red_calc   = diag_sum;
                green_calc = edge_sum;
                blue_calc  = own_val;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= s1_pos_reg.produce;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            red_reg       <= red_calc;
            green_reg     <= green_calc;
            blue_reg      <= blue_calc;
            row_end_reg   <= s1_pos_reg.last_col;
            frame_end_reg <= s1_pos_reg.last_col && s1_pos_reg.last_row;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_value   = red_reg;
    assign green_value = green_reg;
    assign blue_value  = blue_reg;
    assign row_end     = row_end_reg;
    assign frame_end   = frame_end_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_end_reg |-> row_end_reg)
        else $error("frame end without row end");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_cnt_reg <= width_m1)
        else $error("column counter beyond frame width");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input accepted while pipeline is full");

    a_interior_gives_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_pos_reg.produce |=> out_valid_reg)
        else $error("interior pixel lost");

endmodule

`default_nettype wire
